@@ hw/rtl/nrmc_pkg.sv @@
`timescale 1ns / 1ps
// nrmc_pkg: shared constants, event type and lookup helpers of the GPRMC position parser.
// No dependencies; used by every other file of the block.
package nrmc_pkg;

	// Default configuration handed down from the top level
	localparam int unsigned FRACTION_DIGITS_DEF = 5;
	localparam int unsigned FRACTION_DIGITS_MAX = 7;
	localparam int unsigned FIFO_DEPTH_DEF      = 4;

	// Number format limits
	localparam int unsigned INT_DIGITS_MAX = 5;
	localparam int unsigned INT_W          = 17;
	localparam int unsigned IDS_W          = 3;
	localparam int unsigned FRAC_MAX_W     = 24;
	localparam int unsigned FDS_W          = 3;
	localparam int unsigned DEG_W          = 10;
	localparam int unsigned POS_W          = 30;
	localparam int unsigned DEG_DIVISOR    = 100;
	localparam int unsigned MICRO_PER_DEG  = 1000000;
	localparam int unsigned VALID_LIMIT    = 100000;

	// Sentence header
	localparam int unsigned PFX_LEN = 6;
	localparam int unsigned PFX_W   = 3;

	// Characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Field positions after the header
	localparam int unsigned FIELD_W = 3;
	localparam logic [FIELD_W-1:0] FLD_TIME   = 3'd0;
	localparam logic [FIELD_W-1:0] FLD_STATUS = 3'd1;
	localparam logic [FIELD_W-1:0] FLD_LAT    = 3'd2;
	localparam logic [FIELD_W-1:0] FLD_NS     = 3'd3;
	localparam logic [FIELD_W-1:0] FLD_LON    = 3'd4;
	localparam logic [FIELD_W-1:0] FLD_DONE   = 3'd5;

	// Work handed from the front to the back
	typedef enum logic [1:0] {
		EV_LAT,
		EV_LON,
		EV_EMIT
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t                kind;
		logic [INT_W-1:0]        int_acc;
		logic [FRAC_MAX_W-1:0]   frac_acc;
		logic [FDS_W-1:0]        frac_cnt;
		logic                    lon_ok;
		logic                    matched;
		logic                    err;
	} nrmc_event_t;

	// Expected header character at each position
	function automatic logic [7:0] pfx_char(input logic [PFX_W-1:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h47; // G
			3'd1:    ch = 8'h50; // P
			3'd2:    ch = 8'h52; // R
			3'd3:    ch = 8'h4D; // M
			3'd4:    ch = 8'h43; // C
			3'd5:    ch = CH_COMMA;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Powers of ten as a small constant table
	function automatic logic [63:0] pow10(input logic [3:0] n);
		logic [63:0] p;
		case (n)
			4'd0:    p = 64'd1;
			4'd1:    p = 64'd10;
			4'd2:    p = 64'd100;
			4'd3:    p = 64'd1000;
			4'd4:    p = 64'd10000;
			4'd5:    p = 64'd100000;
			4'd6:    p = 64'd1000000;
			4'd7:    p = 64'd10000000;
			4'd8:    p = 64'd100000000;
			4'd9:    p = 64'd1000000000;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

endpackage

@@ hw/rtl/nrmc_stream_if.sv @@
`timescale 1ns / 1ps
// nrmc_byte_if and nrmc_result_if: valid/ready channels of the GPRMC position parser.
// Depends on nrmc_pkg for the position width.
interface nrmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_result_if;
	logic                         valid;
	logic                         ready;
	logic [nrmc_pkg::POS_W-1:0]   latitude_micro_deg;
	logic [nrmc_pkg::POS_W-1:0]   longitude_micro_deg;
	logic                         sentence_matched;
	logic                         parse_error;
	logic                         position_valid;

	modport source (output valid, output latitude_micro_deg, output longitude_micro_deg,
		output sentence_matched, output parse_error, output position_valid, input ready);
	modport sink (input valid, input latitude_micro_deg, input longitude_micro_deg,
		input sentence_matched, input parse_error, input position_valid, output ready);
endinterface

@@ hw/rtl/nmea_rmc_position_parser_top.sv @@
`timescale 1ns / 1ps
// nmea_rmc_position_parser_top: GPRMC sentence parser, front classifier, event queue, back converter.
// Depends on nrmc_pkg, nrmc_stream_if, nrmc_front, nrmc_fifo and nrmc_back.
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+------------
//   rx       | in  | rx_byte[7:0]                                    | valid/ready
//   result   | out | latitude/longitude_micro_deg[29:0], matched,    | valid/ready
//            |     | parse_error, position_valid                     |
//
// One byte is accepted per cycle while the event queue has room.
// A result becomes valid once the emit event of its newline has passed through the queue,
// then the seven-stage conversion pipeline and the result register.
// A stalled result freezes the back pipeline; the front keeps taking bytes until
// FIFO_DEPTH events are queued.
// Reset opens a sentence as if '$' had arrived and clears the stored position; no clearing pass.
module nmea_rmc_position_parser_top #(
	parameter int unsigned FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS_DEF,
	parameter int unsigned FIFO_DEPTH      = nrmc_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	nrmc_byte_if.sink     rx,
	nrmc_result_if.source result
);
	import nrmc_pkg::*;

	logic        fe_push;
	nrmc_event_t fe_event;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	nrmc_event_t q_head;

	// Classify bytes and post events
	nrmc_front #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.push      (fe_push),
		.push_data (fe_event)
	);

	// Decouple front and back
	nrmc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_data (fe_event),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	// Convert, store and report
	nrmc_back #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_data  (q_head),
		.result  (result)
	);

endmodule

@@ hw/rtl/nrmc_front.sv @@
`timescale 1ns / 1ps
// nrmc_front: byte classifier; tracks header, fields and number accumulation,
// and posts conversion and emit events. Depends on nrmc_pkg and nrmc_byte_if.
module nrmc_front #(
	parameter int unsigned FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nrmc_byte_if.sink             rx,
	input  logic                  q_full,
	output logic                  push,
	output nrmc_pkg::nrmc_event_t push_data
);
	import nrmc_pkg::*;

	localparam int unsigned FRAC_W = $clog2(pow10(4'(FRACTION_DIGITS)));

	logic                 in_sent_q, in_sent_d;
	logic [PFX_W-1:0]     pfx_q, pfx_d;
	logic                 fail_q, fail_d;
	logic [FIELD_W-1:0]   fld_q, fld_d;
	logic [INT_W-1:0]     int_q, int_d;
	logic [FRAC_W-1:0]    frac_q, frac_d;
	logic [FDS_W-1:0]     fcnt_q, fcnt_d;
	logic                 pt_q, pt_d;
	logic                 ovf_q, ovf_d;
	logic [IDS_W-1:0]     ids_q, ids_d;

	logic       acc;
	logic [7:0] ch;
	logic [7:0] ch_off;
	logic [3:0] digit;
	logic       matched;
	logic       num_upd;
	logic       num_clr;

	// Accept whenever the queue has room
	assign rx.ready = !q_full;
	assign acc      = rx.valid && rx.ready;
	assign ch       = rx.rx_byte;
	assign ch_off   = ch - CH_ZERO;
	assign digit    = (ch inside {[CH_ZERO:CH_NINE]}) ? ch_off[3:0] : 4'd0;
	assign matched  = (pfx_q == PFX_W'(PFX_LEN)) && !fail_q;

	// Classify the byte and work out the next state
	always_comb begin
		in_sent_d = in_sent_q;
		pfx_d     = pfx_q;
		fail_d    = fail_q;
		fld_d     = fld_q;
		int_d     = int_q;
		frac_d    = frac_q;
		fcnt_d    = fcnt_q;
		pt_d      = pt_q;
		ovf_d     = ovf_q;
		ids_d     = ids_q;
		num_upd   = 1'b0;
		num_clr   = 1'b0;
		push      = 1'b0;

		push_data          = '0;
		push_data.kind     = EV_EMIT;
		push_data.int_acc  = int_q;
		push_data.frac_acc = FRAC_MAX_W'(frac_q);
		push_data.frac_cnt = fcnt_q;
		push_data.lon_ok   = !ovf_q;
		push_data.matched  = matched;
		push_data.err      = matched && ((fld_q < FLD_DONE) || ovf_q);

		if (acc) begin
			if (ch == CH_DOLLAR) begin
				in_sent_d = 1'b1;
				pfx_d     = '0;
				fail_d    = 1'b0;
				fld_d     = FLD_TIME;
				ovf_d     = 1'b0;
				num_clr   = 1'b1;
			end else if (in_sent_q) begin
				if (ch == CH_NL) begin
					push           = 1'b1;
					push_data.kind = EV_EMIT;
					in_sent_d      = 1'b0;
				end else if (!fail_q) begin
					if (pfx_q < PFX_W'(PFX_LEN)) begin
						if (ch == pfx_char(pfx_q)) begin
							pfx_d = pfx_q + 1'b1;
						end else begin
							fail_d = 1'b1;
						end
					end else begin
						case (fld_q)
							FLD_TIME, FLD_STATUS, FLD_NS: begin
								if (ch == CH_COMMA) begin
									fld_d   = fld_q + 1'b1;
									num_clr = 1'b1;
								end
							end
							FLD_LAT: begin
								if (ch == CH_COMMA) begin
									push           = 1'b1;
									push_data.kind = EV_LAT;
									fld_d          = FLD_NS;
								end else begin
									num_upd = 1'b1;
								end
							end
							FLD_LON: begin
								if (ch == CH_COMMA) begin
									push           = 1'b1;
									push_data.kind = EV_LON;
									fld_d          = FLD_DONE;
								end else begin
									num_upd = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
		end

		// Drop the number in progress
		if (num_clr) begin
			int_d  = '0;
			frac_d = '0;
			fcnt_d = '0;
			pt_d   = 1'b0;
			ids_d  = '0;
		end

		// Accumulate one number character; non-digits count as zero
		if (num_upd) begin
			if (!pt_q) begin
				if (ch == CH_POINT) begin
					pt_d = 1'b1;
				end else if (ids_q >= IDS_W'(INT_DIGITS_MAX)) begin
					ovf_d = 1'b1;
				end else begin
					ids_d = ids_q + 1'b1;
					int_d = INT_W'(int_q * INT_W'(10) + INT_W'(digit));
				end
			end else if (fcnt_q < FDS_W'(FRACTION_DIGITS)) begin
				fcnt_d = fcnt_q + 1'b1;
				frac_d = FRAC_W'(frac_q * FRAC_W'(10) + FRAC_W'(digit));
			end
		end
	end

	// Hold parser state; reset behaves as if a '$' had just arrived
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b1;
			pfx_q     <= '0;
			fail_q    <= 1'b0;
			fld_q     <= FLD_TIME;
			int_q     <= '0;
			frac_q    <= '0;
			fcnt_q    <= '0;
			pt_q      <= 1'b0;
			ovf_q     <= 1'b0;
			ids_q     <= '0;
		end else begin
			in_sent_q <= in_sent_d;
			pfx_q     <= pfx_d;
			fail_q    <= fail_d;
			fld_q     <= fld_d;
			int_q     <= int_d;
			frac_q    <= frac_d;
			fcnt_q    <= fcnt_d;
			pt_q      <= pt_d;
			ovf_q     <= ovf_d;
			ids_q     <= ids_d;
		end
	end

`ifndef SYNTH
	a_pfx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pfx_q <= PFX_W'(PFX_LEN))
		else $error("header position beyond header length");
	a_fld_range: assert property (@(posedge clk) disable iff (!arst_n)
		fld_q <= FLD_DONE)
		else $error("field counter beyond last field");
	a_ids_range: assert property (@(posedge clk) disable iff (!arst_n)
		ids_q <= IDS_W'(INT_DIGITS_MAX))
		else $error("integer digit count beyond limit");
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.kind == EV_EMIT) |=> !in_sent_q)
		else $error("sentence still open after emit");
`endif

endmodule

@@ hw/rtl/nrmc_fifo.sv @@
`timescale 1ns / 1ps
// nrmc_fifo: short event queue between the front and back of the parser.
// Depends on nrmc_pkg for the event type.
module nrmc_fifo #(
	parameter int unsigned DEPTH = nrmc_pkg::FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  nrmc_pkg::nrmc_event_t push_data,
	output logic                  full,
	input  logic                  pop,
	output nrmc_pkg::nrmc_event_t pop_data,
	output logic                  empty
);
	import nrmc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nrmc_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from an empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after a push");
`endif

endmodule

@@ hw/rtl/nrmc_back.sv @@
`timescale 1ns / 1ps
// nrmc_back: conversion pipeline (ddmm.f to micro-degrees), position store and result register.
// Depends on nrmc_pkg and nrmc_result_if.
module nrmc_back #(
	parameter int unsigned FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  nrmc_pkg::nrmc_event_t q_data,
	nrmc_result_if.source         result
);
	import nrmc_pkg::*;

	// Minutes are scaled to SCALE units; micro-degrees = minutes * NUM / DEN
	localparam logic [63:0] SCALE  = pow10(4'(FRACTION_DIGITS));
	localparam logic [63:0] NUM    = (FRACTION_DIGITS < 5) ? pow10(4'(5 - FRACTION_DIGITS)) : 64'd1;
	localparam logic [63:0] DEN    = (FRACTION_DIGITS > 5) ?
		64'd6 * pow10(4'(FRACTION_DIGITS - 5)) : 64'd6;
	localparam int unsigned FRAC_W = $clog2(SCALE);
	localparam int unsigned MIN_W  = $clog2(64'd100 * SCALE);
	localparam logic [63:0] X_MAX  = 64'd100 * SCALE * NUM;
	localparam int unsigned X_W    = $clog2(X_MAX);
	localparam logic [63:0] RECIP_X = (64'd1 << X_W) / DEN;
	localparam int unsigned Q_W    = $clog2(X_MAX / DEN + 1);
	localparam int unsigned RR_W   = $clog2(64'd2 * DEN);
	localparam logic [63:0] RECIP_D = (64'd1 << INT_W) / DEG_DIVISOR;
	localparam int unsigned REM0_W = 8;
	localparam int unsigned REM_W  = 7;
	localparam int unsigned P_W    = 2 * INT_W;
	localparam int unsigned PX_W   = 2 * X_W;

	typedef struct packed {
		ev_kind_t kind;
		logic     lon_ok;
		logic     matched;
		logic     err;
	} ctl_t;

	logic adv;
	ctl_t ctl_in;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [P_W-1:0]      pdeg_s1;
	logic [INT_W-1:0]    int_s1;
	logic [FRAC_W-1:0]   fscl_s1, fscl_s2, fscl_s3;
	logic [DEG_W-1:0]    deg0_s2, deg_s3, deg_s4, deg_s5, deg_s6;
	logic [REM0_W-1:0]   rem0_s2;
	logic [REM_W-1:0]    rem_s3;
	logic [X_W-1:0]      x_s4, x_s5;
	logic [PX_W-1:0]     px_s5;
	logic [Q_W-1:0]      qx0_s6;
	logic [RR_W-1:0]     rr_s6;
	logic [POS_W-1:0]    pos_s7;

	logic [3:0]          fidx;
	logic [63:0]         fpow;
	logic [DEG_W-1:0]    deg0_c;
	logic [MIN_W-1:0]    minutes_c;
	logic [Q_W-1:0]      qx0_c;

	logic                out_v_q;
	logic [POS_W-1:0]    pend_q, slat_q, slon_q;
	logic [POS_W-1:0]    olat_q, olon_q;
	logic                omatch_q, oerr_q, ovalid_q;
	logic                commit;

	// Move the whole pipeline only when the result register can take a result
	assign adv    = !out_v_q || result.ready;
	assign q_pop  = adv && !q_empty;
	assign commit = adv && v_s7;

	assign ctl_in.kind    = q_data.kind;
	assign ctl_in.lon_ok  = q_data.lon_ok;
	assign ctl_in.matched = q_data.matched;
	assign ctl_in.err     = q_data.err;

	assign fidx      = 4'(FRACTION_DIGITS) - {1'b0, q_data.frac_cnt};
	assign fpow      = pow10(fidx);
	assign deg0_c    = pdeg_s1[INT_W +: DEG_W];
	assign minutes_c = MIN_W'(rem_s3) * MIN_W'(SCALE) + MIN_W'(fscl_s3);
	assign qx0_c     = px_s5[X_W +: Q_W];

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Conversion datapath: degree split, minutes scaling, divide by constant
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: reciprocal product for /100, align the fraction
			ctl_s1  <= ctl_in;
			int_s1  <= q_data.int_acc;
			pdeg_s1 <= P_W'(q_data.int_acc) * P_W'(RECIP_D);
			fscl_s1 <= FRAC_W'(q_data.frac_acc[FRAC_W-1:0] * fpow[FRAC_W-1:0]);
			// s2: estimated degrees and remainder
			ctl_s2  <= ctl_s1;
			deg0_s2 <= deg0_c;
			rem0_s2 <= REM0_W'(int_s1 - INT_W'(deg0_c) * INT_W'(DEG_DIVISOR));
			fscl_s2 <= fscl_s1;
			// s3: correct the estimate by one step
			ctl_s3  <= ctl_s2;
			fscl_s3 <= fscl_s2;
			if (rem0_s2 >= REM0_W'(DEG_DIVISOR)) begin
				deg_s3 <= deg0_s2 + 1'b1;
				rem_s3 <= REM_W'(rem0_s2 - REM0_W'(DEG_DIVISOR));
			end else begin
				deg_s3 <= deg0_s2;
				rem_s3 <= REM_W'(rem0_s2);
			end
			// s4: scaled minutes
			ctl_s4  <= ctl_s3;
			deg_s4  <= deg_s3;
			x_s4    <= X_W'(minutes_c) * X_W'(NUM);
			// s5: reciprocal product for the minutes divide
			ctl_s5  <= ctl_s4;
			deg_s5  <= deg_s4;
			x_s5    <= x_s4;
			px_s5   <= PX_W'(x_s4) * PX_W'(RECIP_X);
			// s6: estimated quotient and remainder
			ctl_s6  <= ctl_s5;
			deg_s6  <= deg_s5;
			qx0_s6  <= qx0_c;
			rr_s6   <= RR_W'(x_s5 - X_W'(qx0_c) * X_W'(DEN));
			// s7: corrected quotient plus whole degrees
			ctl_s7  <= ctl_s6;
			pos_s7  <= POS_W'(deg_s6) * POS_W'(MICRO_PER_DEG) + POS_W'(qx0_s6)
				+ POS_W'(rr_s6 >= RR_W'(DEN));
		end
	end

	// Commit positions and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= '0;
			slat_q  <= '0;
			slon_q  <= '0;
		end else begin
			if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (commit) begin
				case (ctl_s7.kind)
					EV_LAT: begin
						pend_q <= pos_s7;
					end
					EV_LON: begin
						if (ctl_s7.lon_ok) begin
							slat_q <= pend_q;
							slon_q <= pos_s7;
						end
					end
					EV_EMIT: begin
						out_v_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (commit && ctl_s7.kind == EV_EMIT) begin
			olat_q   <= slat_q;
			olon_q   <= slon_q;
			omatch_q <= ctl_s7.matched;
			oerr_q   <= ctl_s7.err;
			ovalid_q <= (slat_q > POS_W'(VALID_LIMIT));
		end
	end

	assign result.valid               = out_v_q;
	assign result.latitude_micro_deg  = olat_q;
	assign result.longitude_micro_deg = olon_q;
	assign result.sentence_matched    = omatch_q;
	assign result.parse_error         = oerr_q;
	assign result.position_valid      = ovalid_q;

`ifndef SYNTH
	a_deg_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem0_s2 < REM0_W'(2 * DEG_DIVISOR)))
		else $error("degree estimate off by more than one");
	a_min_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (rr_s6 < RR_W'(64'd2 * DEN)))
		else $error("minutes quotient estimate off by more than one");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s7) |=> (v_s7 && $stable(pos_s7)))
		else $error("final stage lost while the result register is stalled");
`endif

endmodule
